FILE: sv/qtg_pkg.sv
package qtg_pkg;

  localparam int QUEUE_DEPTH     = 8;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QW              = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW              = $clog2(QUEUE_DEPTH + 1);
  localparam int QSIZE           = 1 << (SINE_TABLE_BITS - 2);
  localparam int UW              = SINE_TABLE_BITS - 1;

  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 40;
  localparam int SQ_W      = 32;
  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 21;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam logic [14:0] AMP_RESET = 15'd28000;

  localparam logic [63:0] K_C1  = 64'd1686629713;
  localparam logic [63:0] K_C3  = 64'd693598669;
  localparam logic [63:0] K_C5  = 64'd85569306;
  localparam logic [63:0] K_C7  = 64'd5026994;
  localparam logic [63:0] K_C9  = 64'd172272;
  localparam logic [63:0] K_C11 = 64'd3864;

  // Envelope regions
  localparam logic [1:0] REG_RISE    = 2'd0;
  localparam logic [1:0] REG_DECAY   = 2'd1;
  localparam logic [1:0] REG_SUSTAIN = 2'd2;
  localparam logic [1:0] REG_FADE    = 2'd3;

  // Datapath commands
  localparam logic [4:0] CMD_NOP     = 5'd0;
  localparam logic [4:0] CMD_LOAD    = 5'd1;
  localparam logic [4:0] CMD_PUSH    = 5'd2;
  localparam logic [4:0] CMD_EMPTY   = 5'd3;
  localparam logic [4:0] CMD_PREP    = 5'd4;
  localparam logic [4:0] CMD_M_PP    = 5'd5;
  localparam logic [4:0] CMD_M_PPN   = 5'd6;
  localparam logic [4:0] CMD_M_DK    = 5'd7;
  localparam logic [4:0] CMD_M_FF    = 5'd8;
  localparam logic [4:0] CMD_M_RR    = 5'd9;
  localparam logic [4:0] CMD_M_SRR   = 5'd10;
  localparam logic [4:0] CMD_M_AV    = 5'd11;
  localparam logic [4:0] CMD_M_AVM   = 5'd12;
  localparam logic [4:0] CMD_DIV_A   = 5'd13;
  localparam logic [4:0] CMD_DIV_DEN = 5'd14;
  localparam logic [4:0] CMD_SQRT    = 5'd15;
  localparam logic [4:0] CMD_VOL     = 5'd16;
  localparam logic [4:0] CMD_FIN     = 5'd17;

  typedef struct packed {
    logic        op;
    logic [31:0] tuning_word;
    logic [23:0] note_length;
    logic [19:0] attack_length;
    logic [19:0] fade_length;
    logic [15:0] peak_level;
    logic [15:0] sustain_level;
  } item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               accepted;
    logic [3:0]         queue_count;
  } result_t;

  typedef struct packed {
    logic [31:0] step;
    logic [23:0] total;
    logic [19:0] rise;
    logic [19:0] fall;
    logic [15:0] peak;
    logic [15:0] hold;
  } entry_t;

  typedef struct packed {
    logic [4:0] code;
  } ctrl_t;

  typedef struct packed {
    logic       is_push;
    logic       empty;
    logic [1:0] region;
    logic       div_done;
    logic       sqrt_done;
  } stat_t;

  typedef logic [14:0] sine_arr_t [0:QSIZE];

  // Quarter-wave sine magnitudes, 32767 full scale
  function automatic sine_arr_t sine_table();
    sine_arr_t   t;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] mag;
    for (int u = 0; u <= QSIZE; u++) begin
      z   = 64'(u) << (32 - SINE_TABLE_BITS);
      z2  = (z * z) >> 30;
      h   = K_C9 - ((z2 * K_C11) >> 30);
      h   = K_C7 - ((z2 * h) >> 30);
      h   = K_C5 - ((z2 * h) >> 30);
      h   = K_C3 - ((z2 * h) >> 30);
      h   = K_C1 - ((z2 * h) >> 30);
      s   = (z * h) >> 30;
      mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      t[u] = 15'(mag);
    end
    return t;
  endfunction

  localparam sine_arr_t SINE_Q = sine_table();

endpackage

FILE: sv/qtg_div.sv
module qtg_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [qtg_pkg::DIV_NUM_W-1:0]  num,
  input  logic [qtg_pkg::DIV_DEN_W-1:0]  den,
  output logic [qtg_pkg::DIV_NUM_W-1:0]  quo,
  output logic                           done
);
  import qtg_pkg::*;

  localparam int NW = $clog2(DIV_NUM_W);

  logic                 running;
  logic [NW-1:0]        cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  // One quotient bit a cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == NW'(DIV_NUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      dvs <= den;
      rem <= '0;
    end else if (running) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, dvs}) : DIV_DEN_W'(trial);
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

FILE: sv/qtg_sqrt.sv
module qtg_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [qtg_pkg::SQ_W-1:0]  radicand,
  output logic [qtg_pkg::SQ_W/2-1:0] root,
  output logic                      done
);
  import qtg_pkg::*;

  localparam int SW = $clog2(SQ_W / 2);

  logic            running;
  logic [SW-1:0]   cnt;
  logic [SQ_W-1:0] v;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitm;
  logic [SQ_W-1:0] cand;

  assign cand = res + bitm;
  assign root = res[SQ_W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == SW'(SQ_W / 2 - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // One result bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      res  <= '0;
      bitm <= SQ_W'(1) << (SQ_W - 2);
    end else if (running) begin
      if (v >= cand) begin
        v   <= v - cand;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule

FILE: sv/qtg_dpath.sv
module qtg_dpath (
  input  logic             clk,
  input  logic             rst,
  input  qtg_pkg::ctrl_t   ctrl,
  output qtg_pkg::stat_t   stat,
  input  qtg_pkg::item_t   item,
  input  logic             cfg_we,
  input  logic [14:0]      cfg_data,
  output logic             done,
  output qtg_pkg::result_t result
);
  import qtg_pkg::*;

  entry_t              mem [QUEUE_DEPTH];
  entry_t              head;
  item_t               item_q;
  logic [QW-1:0]       head_slot;
  logic [CW-1:0]       count;
  logic [23:0]         position;
  logic [31:0]         phase;
  logic [14:0]         amp;

  logic                sin_neg;
  logic [14:0]         sin_mag;
  logic [PROD_W-1:0]   prod;
  logic [DIV_DEN_W-1:0] den;
  logic [15:0]         vol;

  logic [QW:0]         tail_sum;
  logic [QW-1:0]       tail;
  logic                push_ok;
  entry_t              new_entry;

  logic [24:0]         two_n;
  logic [20:0]         k;
  logic [15:0]         diff;
  logic [23:0]         r;
  logic [1:0]          region;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic                mul_en;

  logic                div_start;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] quo;
  logic                div_done;
  logic                sq_start;
  logic [SQ_W/2-1:0]   root;
  logic                sq_done;

  logic [SINE_TABLE_BITS-1:0] sidx;
  logic [UW-1:0]       u;
  logic [16:0]         m;
  logic signed [15:0]  smp;
  logic [24:0]         pos_inc;

  // Queue tail and acceptance of a push
  assign tail_sum = {1'b0, head_slot} + (QW+1)'(count);
  assign tail     = (tail_sum >= (QW+1)'(QUEUE_DEPTH)) ?
                    QW'(tail_sum - (QW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
  assign push_ok  = (count < CW'(QUEUE_DEPTH)) && (item_q.note_length != '0);

  assign new_entry = '{step: item_q.tuning_word, total: item_q.note_length,
                       rise: item_q.attack_length, fall: item_q.fade_length,
                       peak: item_q.peak_level, hold: item_q.sustain_level};

  // Envelope region of the head note
  assign two_n = {position, 1'b0};
  assign k     = 21'(two_n - 25'(head.rise));
  assign diff  = (head.peak >= head.hold) ? head.peak - head.hold : head.hold - head.peak;
  assign r     = head.total - position;

  always_comb begin
    if (two_n < 25'(head.rise)) begin
      region = REG_RISE;
    end else if (position < 24'(head.rise)) begin
      region = REG_DECAY;
    end else if (25'(position) + 25'(head.fall) < 25'(head.total)) begin
      region = REG_SUSTAIN;
    end else begin
      region = REG_FADE;
    end
  end

  assign stat = '{is_push: item_q.op, empty: (count == '0), region: region,
                  div_done: div_done, sqrt_done: sq_done};

  // Shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (ctrl.code)
      CMD_M_PP: begin
        mul_a = MUL_A_W'(head.peak);
        mul_b = MUL_B_W'(head.peak);
      end
      CMD_M_PPN: begin
        mul_a = MUL_A_W'(prod[31:0]);
        mul_b = MUL_B_W'(two_n);
      end
      CMD_M_DK: begin
        mul_a = MUL_A_W'(diff);
        mul_b = k;
      end
      CMD_M_FF: begin
        mul_a = MUL_A_W'(head.fall);
        mul_b = MUL_B_W'(head.fall);
      end
      CMD_M_RR: begin
        mul_a = MUL_A_W'(r);
        mul_b = MUL_B_W'(r);
      end
      CMD_M_SRR: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(head.hold);
      end
      CMD_M_AV: begin
        mul_a = MUL_A_W'(amp);
        mul_b = MUL_B_W'(vol);
      end
      CMD_M_AVM: begin
        mul_a = MUL_A_W'(prod[31:0]);
        mul_b = MUL_B_W'(sin_mag);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_start = (ctrl.code == CMD_DIV_A) || (ctrl.code == CMD_DIV_DEN);
  assign div_den   = (ctrl.code == CMD_DIV_A) ? DIV_DEN_W'(head.rise) : den;
  assign sq_start  = (ctrl.code == CMD_SQRT);

  qtg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod[DIV_NUM_W-1:0]),
    .den   (div_den),
    .quo   (quo),
    .done  (div_done)
  );

  qtg_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (quo[SQ_W-1:0]),
    .root     (root),
    .done     (sq_done)
  );

  // Sine lookup by quarter-wave symmetry
  assign sidx = phase[31 -: SINE_TABLE_BITS];
  assign u    = sidx[SINE_TABLE_BITS-2] ?
                UW'(QSIZE) - UW'(sidx[SINE_TABLE_BITS-3:0]) :
                UW'(sidx[SINE_TABLE_BITS-3:0]);

  // Scale and saturate the final product
  assign m = prod[46:30];
  always_comb begin
    if (sin_neg) begin
      smp = (m >= 17'd32768) ? -16'sd32768 : -$signed(m[15:0]);
    end else begin
      smp = (m >= 17'd32767) ? 16'sd32767 : $signed(m[15:0]);
    end
  end

  assign pos_inc = 25'(position) + 25'd1;

  // Queue storage
  always_ff @(posedge clk) begin
    if (ctrl.code == CMD_PUSH && push_ok) begin
      mem[tail] <= new_entry;
    end
    head <= mem[head_slot];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctrl.code == CMD_LOAD) begin
      item_q <= item;
    end
    if (ctrl.code == CMD_PREP) begin
      sin_neg <= sidx[SINE_TABLE_BITS-1];
      sin_mag <= SINE_Q[u];
    end
    if (mul_en) begin
      prod <= mul_p;
    end
    if (ctrl.code == CMD_M_RR) begin
      den <= prod[DIV_DEN_W-1:0];
    end
    if (ctrl.code == CMD_VOL) begin
      unique case (region)
        REG_RISE:    vol <= root;
        REG_DECAY:   vol <= (head.peak >= head.hold) ? head.peak - quo[15:0]
                                                     : head.peak + quo[15:0];
        REG_SUSTAIN: vol <= head.hold;
        default:     vol <= quo[15:0];
      endcase
    end
  end

  // Queue control, note state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      amp       <= AMP_RESET;
      head_slot <= '0;
      count     <= '0;
      position  <= '0;
      phase     <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        amp <= cfg_data;
      end
      unique case (ctrl.code)
        CMD_PUSH: begin
          if (push_ok) begin
            count <= count + 1'b1;
          end
          done          <= 1'b1;
          result.sample <= '0;
          result.accepted <= push_ok;
          result.queue_count <= 4'(push_ok ? count + 1'b1 : count);
        end
        CMD_EMPTY: begin
          done               <= 1'b1;
          result.sample      <= '0;
          result.accepted    <= 1'b0;
          result.queue_count <= 4'(count);
        end
        CMD_FIN: begin
          phase <= phase + head.step;
          done  <= 1'b1;
          result.sample   <= smp;
          result.accepted <= 1'b0;
          if (pos_inc >= 25'(head.total)) begin
            position  <= '0;
            head_slot <= (head_slot == QW'(QUEUE_DEPTH - 1)) ? '0 : head_slot + 1'b1;
            count     <= count - 1'b1;
            result.queue_count <= 4'(count - 1'b1);
          end else begin
            position  <= pos_inc[23:0];
            result.queue_count <= 4'(count);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held past one cycle");

  a_push_silent: assert property (@(posedge clk) disable iff (rst)
    done && result.accepted |-> result.sample == '0)
    else $error("accepted push carries a sample");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctrl.code == CMD_FIN |-> count != '0)
    else $error("sample computed on empty queue");
`endif

endmodule

FILE: sv/qtg_ctrl.sv
module qtg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  qtg_pkg::stat_t stat,
  output qtg_pkg::ctrl_t ctrl,
  output logic           busy
);
  import qtg_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_BRANCH  = 4'd2;
  localparam logic [3:0] S_R_PPN   = 4'd3;
  localparam logic [3:0] S_R_DIV   = 4'd4;
  localparam logic [3:0] S_R_DWAIT = 4'd5;
  localparam logic [3:0] S_SWAIT   = 4'd6;
  localparam logic [3:0] S_D_DIV   = 4'd7;
  localparam logic [3:0] S_DWAIT   = 4'd8;
  localparam logic [3:0] S_F_RR    = 4'd9;
  localparam logic [3:0] S_F_SRR   = 4'd10;
  localparam logic [3:0] S_F_DIV   = 4'd11;
  localparam logic [3:0] S_VOL     = 4'd12;
  localparam logic [3:0] S_AV      = 4'd13;
  localparam logic [3:0] S_AVM     = 4'd14;
  localparam logic [3:0] S_FIN     = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctrl.code  = CMD_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.code  = CMD_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_push) begin
          ctrl.code  = CMD_PUSH;
          state_next = S_IDLE;
        end else if (stat.empty) begin
          ctrl.code  = CMD_EMPTY;
          state_next = S_IDLE;
        end else begin
          ctrl.code  = CMD_PREP;
          state_next = S_BRANCH;
        end
      end
      S_BRANCH: begin
        unique case (stat.region)
          REG_RISE: begin
            ctrl.code  = CMD_M_PP;
            state_next = S_R_PPN;
          end
          REG_DECAY: begin
            ctrl.code  = CMD_M_DK;
            state_next = S_D_DIV;
          end
          REG_SUSTAIN: begin
            ctrl.code  = CMD_VOL;
            state_next = S_AV;
          end
          default: begin
            ctrl.code  = CMD_M_FF;
            state_next = S_F_RR;
          end
        endcase
      end
      S_R_PPN: begin
        ctrl.code  = CMD_M_PPN;
        state_next = S_R_DIV;
      end
      S_R_DIV: begin
        ctrl.code  = CMD_DIV_A;
        state_next = S_R_DWAIT;
      end
      S_R_DWAIT: begin
        if (stat.div_done) begin
          ctrl.code  = CMD_SQRT;
          state_next = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (stat.sqrt_done) begin
          state_next = S_VOL;
        end
      end
      S_D_DIV: begin
        ctrl.code  = CMD_DIV_A;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          state_next = S_VOL;
        end
      end
      S_F_RR: begin
        ctrl.code  = CMD_M_RR;
        state_next = S_F_SRR;
      end
      S_F_SRR: begin
        ctrl.code  = CMD_M_SRR;
        state_next = S_F_DIV;
      end
      S_F_DIV: begin
        ctrl.code  = CMD_DIV_DEN;
        state_next = S_DWAIT;
      end
      S_VOL: begin
        ctrl.code  = CMD_VOL;
        state_next = S_AV;
      end
      S_AV: begin
        ctrl.code  = CMD_M_AV;
        state_next = S_AVM;
      end
      S_AVM: begin
        ctrl.code  = CMD_M_AVM;
        state_next = S_FIN;
      end
      S_FIN: begin
        ctrl.code  = CMD_FIN;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_start_held_off: assert property (@(posedge clk) disable iff (rst)
    busy |-> ctrl.code != CMD_LOAD)
    else $error("item loaded while busy");

  a_fin_then_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.code == CMD_FIN |=> !busy)
    else $error("controller did not return to idle");

  a_div_wait_end: assert property (@(posedge clk) disable iff (rst)
    state == S_DWAIT && stat.div_done |=> state == S_VOL)
    else $error("quotient not taken");
`endif

endmodule

FILE: sv/queued_tone_generator_with_envelope_top.sv
// Queued tone generator with attack / sustain / fade envelope.
//
// Input channel: drive item and raise start; the item is taken at a rising
// edge where start is high and busy is low. op = 1 pushes a note into an
// eight-entry queue (rejected when full or when note_length is zero);
// op = 0 is a tick that produces one signed sample from the head note.
// Result channel: done pulses for one cycle with result valid; the receiver
// must take it then, it cannot stall the block.
// Configuration: cfg_valid / cfg_ready write the 15-bit amplitude; ready is
// always high. Write only while the block is idle.
// Path from start to done: a push or a tick on an empty queue is answered
// from the decide state; a sustain tick needs no divide; a decay or fade tick
// waits on the 56-step serial divider; an attack tick on the divider
// followed by the 16-step serial square root. One item is in flight
// at a time; busy drops in the cycle the result is shown, so the next item
// may be taken at the edge that ends the done cycle.
// Reset (rst, synchronous): queue empty, phase and note position zero,
// amplitude 28000. No clearing pass is needed.
module queued_tone_generator_with_envelope_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  qtg_pkg::item_t   item,
  output logic             done,
  output qtg_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [14:0]      cfg_data
);
  import qtg_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Amplitude register accepts a write in any cycle
  assign cfg_ready = 1'b1;

  qtg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  qtg_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .item     (item),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

endmodule
